// ----- src/cv2d_pkg.sv -----
// shared types and constants for the valid-mode 2d convolution block
// no dependencies
`default_nettype none

package cv2d_pkg;

  localparam int unsigned KernelMaxDef = 8;
  localparam int unsigned MaxColsDef   = 1024;
  localparam int unsigned MaxRowsDef   = 1024;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CoefIdxW = 3;
  localparam int unsigned OutIdxW  = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SumGroup = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKernelRows = 3'd0,
    CfgKernelCols = 3'd1,
    CfgImageRows  = 3'd2,
    CfgImageCols  = 3'd3
  } cfg_idx_e;

  typedef enum logic {
    CmdCoef   = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    logic               valid;
    logic [OutIdxW-1:0] row;
    logic [OutIdxW-1:0] col;
    logic               last;
  } tag_t;

endpackage

`default_nettype wire

// ----- src/cv2d_line_mem.sv -----
// line store: one word per image column holding one sample per kernel row
// synchronous read with registered output, uses cv2d_pkg for parameter defaults
`default_nettype none

module cv2d_line_mem
  import cv2d_pkg::*;
#(
  parameter int unsigned Depth = MaxColsDef,
  parameter int unsigned Width = KernelMaxDef * DataW
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/cv2d_mac_tree.sv -----
// multiply window by kernel lane by lane, then a registered adder tree
// depends on cv2d_pkg
`default_nettype none

module cv2d_mac_tree
  import cv2d_pkg::*;
#(
  parameter int unsigned KernelMax = KernelMaxDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire tag_t                               tag_i,
  input  wire word_t                              win_i  [KernelMax*KernelMax],
  input  wire word_t                              kern_i [KernelMax*KernelMax],
  input  wire logic [$clog2(KernelMax+1)-1:0]     kr_i,
  input  wire logic [$clog2(KernelMax+1)-1:0]     kc_i,
  output tag_t                                    tag_o,
  output word_t                                   sum_o
);

  localparam int unsigned KK = KernelMax * KernelMax;
  localparam int unsigned NG = (KK + SumGroup - 1) / SumGroup;

  word_t prod_d [KK];
  word_t prod_q [KK];
  word_t part_d [NG];
  word_t part_q [NG];
  word_t sum_d;
  word_t sum_q;
  tag_t  tag1_q, tag2_q, tag3_q;

  always_comb begin
    for (int a = 0; a < KernelMax; a++) begin
      for (int b = 0; b < KernelMax; b++) begin
        if (a < int'(kr_i) && b < int'(kc_i)) begin
          prod_d[a*KernelMax+b] = win_i[a*KernelMax+b] * kern_i[a*KernelMax+b];
        end else begin
          prod_d[a*KernelMax+b] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < SumGroup; j++) begin
        if (g * SumGroup + j < KK) begin
          part_d[g] = part_d[g] + prod_q[g*SumGroup+j];
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NG; g++) begin
      sum_d = sum_d + part_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      part_q <= part_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign tag_o = tag3_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- src/conv2d_valid_int32.sv -----
// valid-mode 2d int32 convolution over a raster sample stream
// a result beat passes the p1, window, product, partial, sum and output registers
// one beat per cycle unless stalled, set by single line store read and write port
// KernelMax*KernelMax parallel lane multipliers; lanes outside the kernel give zero
// reset clears position and valids, presets the config; stores are not cleared
// depends on cv2d_pkg, cv2d_line_mem, cv2d_mac_tree
`default_nettype none

module conv2d_valid_int32
  import cv2d_pkg::*;
#(
  parameter int unsigned KernelMax = KernelMaxDef,
  parameter int unsigned MaxCols   = MaxColsDef,
  parameter int unsigned MaxRows   = MaxRowsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 command_i,
  input  wire logic [CoefIdxW-1:0]  coef_row_i,
  input  wire logic [CoefIdxW-1:0]  coef_col_i,
  input  wire logic signed [DataW-1:0] data_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [DataW-1:0]   out_value_o,
  output logic [OutIdxW-1:0]        out_row_o,
  output logic [OutIdxW-1:0]        out_col_o,
  output logic                      out_last_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned KK    = KernelMax * KernelMax;
  localparam int unsigned KW    = $clog2(KernelMax + 1);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned ColW  = $clog2(MaxCols);
  localparam int unsigned IrW   = $clog2(MaxRows + 1);
  localparam int unsigned IcW   = $clog2(MaxCols + 1);
  localparam int unsigned RcW   = IrW + 1;
  localparam int unsigned CcW   = IcW + 1;
  localparam int unsigned SlotW = $clog2(KernelMax);
  localparam int unsigned MemW  = KernelMax * DataW;
  localparam int unsigned KrRst = (3 > KernelMax) ? KernelMax : 3;
  localparam int unsigned IrRst = (1024 > MaxRows) ? MaxRows : 1024;
  localparam int unsigned IcRst = (1024 > MaxCols) ? MaxCols : 1024;

  logic [KW-1:0]  kr_q, kc_q;
  logic [IrW-1:0] ir_q;
  logic [IcW-1:0] ic_q;
  logic [KW-1:0]  cfg_k;
  logic [IrW-1:0] cfg_ir;
  logic [IcW-1:0] cfg_ic;

  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic [SlotW-1:0] slot_q;

  logic en, accept, is_sample, col_end, row_end, produce, last;
  tag_t in_tag;

  logic              p1_v_q;
  cmd_e              p1_cmd_q;
  logic [CoefIdxW-1:0] p1_crow_q, p1_ccol_q;
  word_t             p1_val_q;
  logic [ColW-1:0]   p1_col_q;
  logic [SlotW-1:0]  p1_slot_q;
  tag_t              p1_tag_q;
  tag_t              p2_tag_q;

  logic [MemW-1:0] rdata, cur_word, new_word;
  logic            fwd_q;
  logic [MemW-1:0] fwd_word_q;
  logic            mem_re, mem_we;
  word_t           lane_w  [KernelMax];
  word_t           col_vec [KernelMax];
  word_t           win_q   [KK];
  word_t           kern_q  [KK];

  tag_t  mac_tag;
  word_t mac_sum;
  logic  out_valid_q;

  // configuration, stored already clamped
  always_comb begin
    if (cfg_data_i[3:0] == 4'd0) begin
      cfg_k = KW'(1);
    end else if (32'(cfg_data_i[3:0]) > KernelMax) begin
      cfg_k = KW'(KernelMax);
    end else begin
      cfg_k = KW'(cfg_data_i[3:0]);
    end
    if (cfg_data_i[10:0] == 11'd0) begin
      cfg_ir = IrW'(1);
    end else if (32'(cfg_data_i[10:0]) > MaxRows) begin
      cfg_ir = IrW'(MaxRows);
    end else begin
      cfg_ir = IrW'(cfg_data_i[10:0]);
    end
    if (cfg_data_i[10:0] == 11'd0) begin
      cfg_ic = IcW'(1);
    end else if (32'(cfg_data_i[10:0]) > MaxCols) begin
      cfg_ic = IcW'(MaxCols);
    end else begin
      cfg_ic = IcW'(cfg_data_i[10:0]);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kr_q <= KW'(KrRst);
      kc_q <= KW'(KrRst);
      ir_q <= IrW'(IrRst);
      ic_q <= IcW'(IcRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKernelRows: kr_q <= cfg_k;
        CfgKernelCols: kc_q <= cfg_k;
        CfgImageRows:  ir_q <= cfg_ir;
        CfgImageCols:  ic_q <= cfg_ic;
        default: ;
      endcase
    end
  end

  // handshake and raster position
  assign en         = !(out_valid_q && out_stall_i && mac_tag.valid);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_sample  = (cmd_e'(command_i) == CmdSample);

  assign col_end = (CcW'(col_q) + CcW'(1)) >= CcW'(ic_q);
  assign row_end = (RcW'(row_q) + RcW'(1)) >= RcW'(ir_q);
  assign produce = ((RcW'(row_q) + RcW'(1)) >= RcW'(kr_q))
                && ((CcW'(col_q) + CcW'(1)) >= CcW'(kc_q))
                && (RcW'(ir_q) >= RcW'(kr_q)) && (CcW'(ic_q) >= CcW'(kc_q));
  assign last    = col_end && row_end;

  always_comb begin
    in_tag.valid = produce;
    in_tag.row   = OutIdxW'(RcW'(row_q) + RcW'(1) - RcW'(kr_q));
    in_tag.col   = OutIdxW'(CcW'(col_q) + CcW'(1) - CcW'(kc_q));
    in_tag.last  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (accept && is_sample) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + RowW'(1);
          slot_q <= (32'(slot_q) + 1 >= KernelMax) ? '0 : slot_q + SlotW'(1);
        end
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // stage one: line store read back, updated word, window column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q   <= 1'b0;
      p2_tag_q <= '0;
    end else if (en) begin
      p1_v_q   <= accept;
      p2_tag_q <= '{valid: p1_v_q && (p1_cmd_q == CmdSample) && p1_tag_q.valid,
                    row:   p1_tag_q.row,
                    col:   p1_tag_q.col,
                    last:  p1_tag_q.last};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_cmd_q  <= cmd_e'(command_i);
      p1_crow_q <= coef_row_i;
      p1_ccol_q <= coef_col_i;
      p1_val_q  <= data_value_i;
      p1_col_q  <= col_q;
      p1_slot_q <= slot_q;
      p1_tag_q  <= in_tag;
    end
  end

  assign mem_re = accept && is_sample;
  assign mem_we = en && p1_v_q && (p1_cmd_q == CmdSample);

  cv2d_line_mem #(
    .Depth (MaxCols),
    .Width (MemW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (col_q),
    .rdata_o (rdata),
    .we_i    (mem_we),
    .waddr_i (p1_col_q),
    .wdata_i (new_word)
  );

  // a write landing on the column being read this edge is forwarded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (mem_re) begin
      fwd_q <= mem_we && (p1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      fwd_word_q <= new_word;
    end
  end

  assign cur_word = fwd_q ? fwd_word_q : rdata;

  always_comb begin
    for (int i = 0; i < KernelMax; i++) begin
      if (32'(p1_slot_q) == i) begin
        lane_w[i] = p1_val_q;
      end else begin
        lane_w[i] = cur_word[i*DataW +: DataW];
      end
      new_word[i*DataW +: DataW] = lane_w[i];
    end
  end

  always_comb begin
    for (int a = 0; a < KernelMax; a++) begin
      if (32'(p1_slot_q) >= a) begin
        col_vec[a] = lane_w[SlotW'(32'(p1_slot_q) - a)];
      end else begin
        col_vec[a] = lane_w[SlotW'(32'(p1_slot_q) + KernelMax - a)];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p1_v_q && (p1_cmd_q == CmdSample)) begin
      for (int a = 0; a < KernelMax; a++) begin
        win_q[a*KernelMax] <= col_vec[a];
        for (int b = 1; b < KernelMax; b++) begin
          win_q[a*KernelMax+b] <= win_q[a*KernelMax+b-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p1_v_q && (p1_cmd_q == CmdCoef)) begin
      for (int i = 0; i < KernelMax; i++) begin
        for (int j = 0; j < KernelMax; j++) begin
          if (32'(p1_crow_q) == i && 32'(p1_ccol_q) == j) begin
            kern_q[i*KernelMax+j] <= p1_val_q;
          end
        end
      end
    end
  end

  cv2d_mac_tree #(
    .KernelMax (KernelMax)
  ) u_mac_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (p2_tag_q),
    .win_i  (win_q),
    .kern_i (kern_q),
    .kr_i   (kr_q),
    .kc_i   (kc_q),
    .tag_o  (mac_tag),
    .sum_o  (mac_sum)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && mac_tag.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && mac_tag.valid) begin
      out_value_o <= mac_sum;
      out_row_o   <= mac_tag.row;
      out_col_o   <= mac_tag.col;
      out_last_o  <= mac_tag.last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> row_q == '0 && col_q == '0 && slot_q == '0)
    else $error("position not restarted by register write");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CcW'(col_q) < CcW'(ic_q) && RcW'(row_q) < RcW'(ir_q))
    else $error("raster position outside image");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(mac_tag.valid) && $past(en))
    else $error("result beat without a finished sum");

endmodule

`default_nettype wire
